FILE: design/id_allocator_min_free_set_defines.svh
// Assertion macros shared by the id allocator modules.
`ifndef ID_ALLOCATOR_MIN_FREE_SET_DEFINES_SVH
`define ID_ALLOCATOR_MIN_FREE_SET_DEFINES_SVH

// Check a property on every clock edge outside of reset.
`define IDA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Check that a condition leads to a consequence in the next cycle.
`define IDA_ASSERT_NEXT(lbl, ante, cons, msg) \
    `IDA_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

FILE: design/ida_pkg.sv
// Shared types and constants of the id allocator.
package ida_pkg;

    localparam int ID_W       = 32;
    localparam int FREE_DEPTH = 16;
    localparam int CNT_W      = $clog2(FREE_DEPTH + 1);
    localparam int PADDR_W    = 3;

    // Request kinds
    localparam logic [1:0] KIND_ALLOC    = 2'd0;
    localparam logic [1:0] KIND_BATCH    = 2'd1;
    localparam logic [1:0] KIND_DEALLOC  = 2'd2;
    localparam logic [1:0] KIND_SET_NEXT = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BELOW_USER = 2'd1;
    localparam logic [1:0] ST_SET_FULL   = 2'd2;
    localparam logic [1:0] ST_ZERO_BATCH = 2'd3;

    // Configuration register indexes (selected by paddr[2])
    localparam logic REG_FIRST_USER_ID = 1'b0;
    localparam logic REG_INVALID_ID    = 1'b1;

    // Reset values
    localparam logic [ID_W-1:0] FIRST_USER_ID_RST = 32'd16384;
    localparam logic [ID_W-1:0] INVALID_ID_RST    = 32'd0;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;    // capture the incoming request
        logic commit;  // execute the held request and register its result
    } t_ctrl;

endpackage

FILE: design/ida_ctrl.sv
// Controller of the id allocator: request handshake and result slot.
`include "id_allocator_min_free_set_defines.svh"

module ida_ctrl
    import ida_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_out_stall,
    output logic  o_in_stall,
    output logic  o_out_valid,
    output t_ctrl o_ctrl
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_BUSY = 1'b1;

    logic  r_state;
    logic  n_state;
    logic  r_out_valid;
    logic  n_out_valid;
    t_ctrl ctrl;

    // Execute the held request once the result slot is free or being emptied
    always_comb begin
        ctrl.commit = (r_state == S_BUSY) && (!r_out_valid || !i_out_stall);
        o_in_stall  = (r_state == S_BUSY) && !ctrl.commit;
        ctrl.load   = i_in_valid && !o_in_stall;
    end

    // Advance the state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (ctrl.load) n_state = S_BUSY;
            end
            S_BUSY: begin
                if (ctrl.commit && !ctrl.load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Fill the result slot on commit, drop it when taken
    always_comb begin
        n_out_valid = r_out_valid;
        priority if (ctrl.commit) n_out_valid = 1'b1;
        else if (!i_out_stall)    n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_ctrl      = ctrl;

    `IDA_ASSERT_NEXT(a_load_busy, ctrl.load, r_state == S_BUSY, "accepted request not held")
    `IDA_ASSERT(a_rise_from_busy, $rose(r_out_valid) |-> $past(r_state) == S_BUSY,
                "result appeared without a held request")
    `IDA_ASSERT_NEXT(a_blocked_holds, (r_state == S_BUSY) && r_out_valid && i_out_stall,
                     r_state == S_BUSY, "held request lost while output blocked")

endmodule

FILE: design/ida_datapath.sv
// Datapath of the id allocator: request register, sorted free-id cells, counter, result.
`include "id_allocator_min_free_set_defines.svh"

module ida_datapath
    import ida_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_ctrl           i_ctrl,
    input  logic [1:0]      i_kind,
    input  logic [ID_W-1:0] i_value,
    input  logic [ID_W-1:0] i_first_user_id,
    input  logic [ID_W-1:0] i_invalid_id,
    output logic [ID_W-1:0] o_id,
    output logic [1:0]      o_status,
    output logic [4:0]      o_free_count,
    output logic [ID_W-1:0] o_next_id
);

    logic [1:0]      r_kind;
    logic [ID_W-1:0] r_value;

    // Free ids kept ascending in cells 0 .. r_cnt-1
    logic [ID_W-1:0] r_ids [FREE_DEPTH];
    logic [ID_W-1:0] n_ids [FREE_DEPTH];
    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] n_cnt;
    logic [ID_W-1:0] r_counter;
    logic [ID_W-1:0] n_counter;

    logic [ID_W-1:0] r_id;
    logic [ID_W-1:0] n_id;
    logic [1:0]      r_status;
    logic [1:0]      n_status;
    logic [CNT_W-1:0] r_out_cnt;

    logic [FREE_DEPTH-1:0] valid;
    logic [FREE_DEPTH-1:0] eq;
    logic [FREE_DEPTH-1:0] gt;
    logic [FREE_DEPTH-1:0] gt_prev;
    logic [FREE_DEPTH-1:0] at_end;
    logic                  dup;
    logic                  full;

    // Capture the request
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_kind  <= i_kind;
            r_value <= i_value;
        end
    end

    // Compare the request value against every cell
    always_comb begin
        for (int i = 0; i < FREE_DEPTH; i++) begin
            valid[i]  = CNT_W'(i) < r_cnt;
            at_end[i] = CNT_W'(i) == r_cnt;
            eq[i]     = valid[i] && (r_ids[i] == r_value);
            gt[i]     = valid[i] && (r_ids[i] > r_value);
        end
        gt_prev = {gt[FREE_DEPTH-2:0], 1'b0};
        dup     = |eq;
        full    = r_cnt == CNT_W'(FREE_DEPTH);
    end

    // Execute the request
    always_comb begin
        n_ids     = r_ids;
        n_cnt     = r_cnt;
        n_counter = r_counter;
        n_id      = '0;
        n_status  = ST_OK;
        unique case (r_kind)
            KIND_ALLOC: begin
                if (r_cnt != '0) begin
                    // Pop the smallest id and shift the cells down
                    n_id = r_ids[0];
                    for (int i = 0; i < FREE_DEPTH - 1; i++) begin
                        n_ids[i] = r_ids[i+1];
                    end
                    n_cnt = r_cnt - 1'b1;
                end else begin
                    n_id      = r_counter;
                    n_counter = r_counter + 1'b1;
                end
            end
            KIND_BATCH: begin
                if (r_value == '0) begin
                    n_id     = i_invalid_id;
                    n_status = ST_ZERO_BATCH;
                end else begin
                    n_id      = r_counter;
                    n_counter = r_counter + r_value;
                end
            end
            KIND_DEALLOC: begin
                priority if (r_value < i_first_user_id) begin
                    n_status = ST_BELOW_USER;
                end else if (dup) begin
                    n_status = ST_OK;
                end else if (full) begin
                    n_status = ST_SET_FULL;
                end else begin
                    // Insert in order: larger ids move up one cell
                    for (int i = 0; i < FREE_DEPTH; i++) begin
                        if (gt_prev[i]) begin
                            n_ids[i] = (i > 0) ? r_ids[(i > 0) ? i - 1 : 0] : r_ids[i];
                        end else if (gt[i] || at_end[i]) begin
                            n_ids[i] = r_value;
                        end
                    end
                    n_cnt = r_cnt + 1'b1;
                end
            end
            KIND_SET_NEXT: begin
                n_counter = r_value;
            end
            default: begin
                n_counter = r_counter;
            end
        endcase
    end

    // Update the cells and the result
    always_ff @(posedge i_clk) begin
        if (i_ctrl.commit) begin
            r_ids     <= n_ids;
            r_id      <= n_id;
            r_status  <= n_status;
            r_out_cnt <= n_cnt;
        end
    end

    // Control state: fill count and counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_counter <= FIRST_USER_ID_RST;
        end else if (i_ctrl.commit) begin
            r_cnt     <= n_cnt;
            r_counter <= n_counter;
        end
    end

    assign o_id         = r_id;
    assign o_status     = r_status;
    assign o_free_count = 5'(r_out_cnt);
    assign o_next_id    = r_counter;

    `IDA_ASSERT(a_cnt_bound, r_cnt <= CNT_W'(FREE_DEPTH), "free count beyond depth")
    `IDA_ASSERT_NEXT(a_pop_dec,
                     i_ctrl.commit && (r_kind == KIND_ALLOC) && (r_cnt != '0),
                     r_cnt == $past(r_cnt) - 1'b1, "allocate from set did not pop")

    for (genvar g = 1; g < FREE_DEPTH; g++) begin : g_order
        `IDA_ASSERT(a_sorted, (CNT_W'(g) < r_cnt) |-> (r_ids[g-1] < r_ids[g]),
                    "free cells not strictly ascending")
    end

endmodule

FILE: design/id_allocator_min_free_set.sv
// An accepted request is held in the request register, and its result is then
// written to the result register. With the output not stalled, one request is
// accepted every cycle. The rate is set by the free-id cell chain, which finds the
// smallest freed id, checks duplicates and inserts in order in one combinational
// pass per request. The set holds 16 ids kept in ascending order; allocate reuses
// the smallest, else the 32-bit counter. No clearing pass is needed after reset.
module id_allocator_min_free_set
    import ida_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_kind,
    input  logic [ID_W-1:0]    i_value,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [ID_W-1:0]    o_id,
    output logic [1:0]         o_status,
    output logic [4:0]         o_free_count,
    output logic [ID_W-1:0]    o_next_id,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    logic [ID_W-1:0] r_first_user_id;
    logic [ID_W-1:0] r_invalid_id;
    logic            cfg_wr;
    t_ctrl           ctrl;

    // Write configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_user_id <= FIRST_USER_ID_RST;
            r_invalid_id    <= INVALID_ID_RST;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_FIRST_USER_ID: r_first_user_id <= pwdata;
                REG_INVALID_ID:    r_invalid_id    <= pwdata;
                default:           r_invalid_id    <= r_invalid_id;
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (paddr[2])
            REG_FIRST_USER_ID: prdata = r_first_user_id;
            REG_INVALID_ID:    prdata = r_invalid_id;
            default:           prdata = '0;
        endcase
    end

    ida_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_ctrl      (ctrl)
    );

    ida_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctrl          (ctrl),
        .i_kind          (i_kind),
        .i_value         (i_value),
        .i_first_user_id (r_first_user_id),
        .i_invalid_id    (r_invalid_id),
        .o_id            (o_id),
        .o_status        (o_status),
        .o_free_count    (o_free_count),
        .o_next_id       (o_next_id)
    );

endmodule
